@@ rtl/lct_pkg.sv @@
package lct_pkg;

   // Field widths
   localparam int unsigned SIZE_W     = 32;
   localparam int unsigned WAYS_W     = 11;
   localparam int unsigned KB_W       = 15;
   localparam int unsigned DEC_WAYS_W = 5;
   localparam int unsigned FACTOR_W   = 13;
   localparam int unsigned TYPE_W     = 5;
   localparam int unsigned BYTE_W     = 8;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DESC  = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_MERGE = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   // Input item modes
   typedef enum logic {
      MODE_DESC = 1'b0,
      MODE_LEAF4 = 1'b1
   } mode_type;

endpackage

@@ rtl/lct_if.sv @@
interface lct_req_if;
   logic                               valid;
   logic                               ready;
   logic                               mode;
   logic [lct_pkg::SIZE_W-1:0]         descriptor_word;
   logic [lct_pkg::TYPE_W-1:0]         record_type;
   logic [lct_pkg::SIZE_W-1:0]         record_geometry;
   logic [lct_pkg::SIZE_W-1:0]         record_sets_minus_one;

   modport source (output valid, mode, descriptor_word, record_type, record_geometry,
                   record_sets_minus_one, input ready);
   modport sink   (input valid, mode, descriptor_word, record_type, record_geometry,
                   record_sets_minus_one, output ready);
endinterface

interface lct_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [lct_pkg::SIZE_W-1:0]         largest_size;
   logic [lct_pkg::WAYS_W-1:0]         largest_ways;

   modport source (output valid, largest_size, largest_ways, input ready);
   modport sink   (input valid, largest_size, largest_ways, output ready);
endinterface

@@ rtl/largest_cache_tracker_unit.sv @@
// Largest cache tracker: one item in flight, ready only while idle.
// Steps: a descriptor word is accepted, then goes one byte per cycle through the
// descriptor decoder, then the result is loaded; a leaf-4 record makes three passes
// through the shared saturating multiplier, then a merge and a result load; ignored
// items go from accept straight to the result load, which waits for a free result side.
// Reset (synchronous): kept size and ways clear to zero, sequencer idle, no result.
module largest_cache_tracker_unit (
   input  logic           clock,
   input  logic           reset,
   lct_req_if.sink        req_if,
   lct_rsp_if.source      rsp_if
);

   lct_pkg::state_type                 state_ff, state_in;
   logic [1:0]                         cnt_ff, cnt_in;
   logic [lct_pkg::SIZE_W-1:0]         word_ff, word_in;
   logic [lct_pkg::SIZE_W-1:0]         geo_ff, geo_in;
   logic [lct_pkg::SIZE_W-1:0]         acc_ff, acc_in;
   logic [lct_pkg::SIZE_W-1:0]         kept_size_ff, kept_size_in;
   logic [lct_pkg::WAYS_W-1:0]         kept_ways_ff, kept_ways_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lct_pkg::SIZE_W-1:0]         rsp_size_ff, rsp_size_in;
   logic [lct_pkg::WAYS_W-1:0]         rsp_ways_ff, rsp_ways_in;

   logic                               req_accept;
   logic [lct_pkg::SIZE_W:0]           sets_ext;
   logic [lct_pkg::BYTE_W-1:0]         cur_byte;
   logic [lct_pkg::SIZE_W-1:0]         dec_size;
   logic [lct_pkg::DEC_WAYS_W-1:0]     dec_ways;
   logic [lct_pkg::WAYS_W-1:0]         l4_ways;
   logic [lct_pkg::WAYS_W-1:0]         l4_parts;
   logic [lct_pkg::FACTOR_W-1:0]       l4_line;
   logic [lct_pkg::FACTOR_W-1:0]       factor;
   logic [lct_pkg::SIZE_W-1:0]         mul_p;
   logic                               mg_en;
   logic [lct_pkg::SIZE_W-1:0]         mg_size;
   logic [lct_pkg::WAYS_W-1:0]         mg_ways;

   assign req_accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == lct_pkg::ST_IDLE);

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.largest_size = rsp_size_ff;
   assign rsp_if.largest_ways = rsp_ways_ff;

   // sets count, with the carry kept for saturation
   assign sets_ext = {1'b0, req_if.record_sets_minus_one} + {{lct_pkg::SIZE_W{1'b0}}, 1'b1};

   // byte under decode, low byte first
   assign cur_byte = word_ff[{cnt_ff, 3'b000} +: lct_pkg::BYTE_W];

   lct_desc_dec u_dec (
      .desc_i (cur_byte),
      .size_o (dec_size),
      .ways_o (dec_ways)
   );

   // leaf-4 factors
   assign l4_ways  = {1'b0, geo_ff[31:22]} + {{(lct_pkg::WAYS_W-1){1'b0}}, 1'b1};
   assign l4_parts = {1'b0, geo_ff[21:12]} + {{(lct_pkg::WAYS_W-1){1'b0}}, 1'b1};
   assign l4_line  = {1'b0, geo_ff[11:0]} + {{(lct_pkg::FACTOR_W-1){1'b0}}, 1'b1};

   always_comb begin
      unique case (cnt_ff)
         2'd0:    factor = {{(lct_pkg::FACTOR_W-lct_pkg::WAYS_W){1'b0}}, l4_ways};
         2'd1:    factor = {{(lct_pkg::FACTOR_W-lct_pkg::WAYS_W){1'b0}}, l4_parts};
         default: factor = l4_line;
      endcase
   end

   lct_sat_mul u_mul (
      .a_i (acc_ff),
      .b_i (factor),
      .p_o (mul_p)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      word_in      = word_ff;
      geo_in       = geo_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_ways_in  = rsp_ways_ff;
      mg_en        = 1'b0;
      mg_size      = dec_size;
      mg_ways      = {{(lct_pkg::WAYS_W-lct_pkg::DEC_WAYS_W){1'b0}}, dec_ways};

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         lct_pkg::ST_IDLE: begin
            if (req_accept) begin
               word_in = req_if.descriptor_word;
               geo_in  = req_if.record_geometry;
               acc_in  = sets_ext[lct_pkg::SIZE_W] ? '1 : sets_ext[lct_pkg::SIZE_W-1:0];
               cnt_in  = 2'd0;
               if (req_if.mode == lct_pkg::MODE_DESC) begin
                  state_in = req_if.descriptor_word[31] ? lct_pkg::ST_EMIT : lct_pkg::ST_DESC;
               end else begin
                  state_in = (req_if.record_type != '0) ? lct_pkg::ST_MUL : lct_pkg::ST_EMIT;
               end
            end
         end
         lct_pkg::ST_DESC: begin
            mg_en  = 1'b1;
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = lct_pkg::ST_EMIT;
            end
         end
         lct_pkg::ST_MUL: begin
            acc_in = mul_p;
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) begin
               state_in = lct_pkg::ST_MERGE;
            end
         end
         lct_pkg::ST_MERGE: begin
            mg_en    = 1'b1;
            mg_size  = acc_ff;
            mg_ways  = l4_ways;
            state_in = lct_pkg::ST_EMIT;
         end
         lct_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_size_in  = kept_size_ff;
               rsp_ways_in  = kept_ways_ff;
               state_in     = lct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lct_pkg::ST_IDLE;
         end
      endcase
   end

   // merge into the kept pair: larger size wins, equal size keeps more ways
   always_comb begin
      kept_size_in = kept_size_ff;
      kept_ways_in = kept_ways_ff;
      if (mg_en) begin
         priority if (mg_size > kept_size_ff) begin
            kept_size_in = mg_size;
            kept_ways_in = mg_ways;
         end else if ((mg_size == kept_size_ff) && (mg_ways > kept_ways_ff)) begin
            kept_ways_in = mg_ways;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lct_pkg::ST_IDLE;
         cnt_ff       <= '0;
         kept_size_ff <= '0;
         kept_ways_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         kept_size_ff <= kept_size_in;
         kept_ways_ff <= kept_ways_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      geo_ff      <= geo_in;
      acc_ff      <= acc_in;
      rsp_size_ff <= rsp_size_in;
      rsp_ways_ff <= rsp_ways_in;
   end

`ifndef ASSERT_OFF
   // kept size only grows between resets
   a_size_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (kept_size_ff >= $past(kept_size_ff)))
      else $error("kept size decreased");

   // an accepted item makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != lct_pkg::ST_IDLE))
      else $error("still idle after accepting an item");

   // a new result only comes out of the load step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == lct_pkg::ST_EMIT))
      else $error("result raised outside the load step");

   // multiplier pass counter stays within the three factors
   a_mul_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lct_pkg::ST_MUL) |-> (cnt_ff != 2'd3))
      else $error("multiplier step out of range");
`endif

endmodule

@@ rtl/lct_desc_dec.sv @@
// Leaf-2 descriptor byte decode: size in bytes and associativity.
// Unknown and null descriptors give zero size and zero ways.
module lct_desc_dec (
   input  logic [lct_pkg::BYTE_W-1:0]     desc_i,
   output logic [lct_pkg::SIZE_W-1:0]     size_o,
   output logic [lct_pkg::DEC_WAYS_W-1:0] ways_o
);

   logic [lct_pkg::KB_W-1:0] kb;

   // descriptor table
   always_comb begin
      unique case (desc_i)
         8'h06: begin kb = 15'd8;     ways_o = 5'd4;  end
         8'h08: begin kb = 15'd16;    ways_o = 5'd4;  end
         8'h09: begin kb = 15'd32;    ways_o = 5'd4;  end
         8'h0A: begin kb = 15'd8;     ways_o = 5'd2;  end
         8'h0C: begin kb = 15'd16;    ways_o = 5'd4;  end
         8'h0D: begin kb = 15'd16;    ways_o = 5'd4;  end
         8'h0E: begin kb = 15'd24;    ways_o = 5'd6;  end
         8'h21: begin kb = 15'd256;   ways_o = 5'd8;  end
         8'h22: begin kb = 15'd512;   ways_o = 5'd4;  end
         8'h23: begin kb = 15'd1024;  ways_o = 5'd8;  end
         8'h25: begin kb = 15'd2048;  ways_o = 5'd8;  end
         8'h29: begin kb = 15'd4096;  ways_o = 5'd8;  end
         8'h2C: begin kb = 15'd32;    ways_o = 5'd8;  end
         8'h30: begin kb = 15'd32;    ways_o = 5'd8;  end
         8'h41: begin kb = 15'd128;   ways_o = 5'd4;  end
         8'h42: begin kb = 15'd256;   ways_o = 5'd4;  end
         8'h43: begin kb = 15'd512;   ways_o = 5'd4;  end
         8'h44: begin kb = 15'd1024;  ways_o = 5'd4;  end
         8'h45: begin kb = 15'd2048;  ways_o = 5'd4;  end
         8'h46: begin kb = 15'd4096;  ways_o = 5'd4;  end
         8'h47: begin kb = 15'd8192;  ways_o = 5'd8;  end
         8'h48: begin kb = 15'd3072;  ways_o = 5'd12; end
         8'h49: begin kb = 15'd4096;  ways_o = 5'd16; end
         8'h4A: begin kb = 15'd6144;  ways_o = 5'd12; end
         8'h4B: begin kb = 15'd8192;  ways_o = 5'd16; end
         8'h4C: begin kb = 15'd12288; ways_o = 5'd12; end
         8'h4D: begin kb = 15'd16384; ways_o = 5'd16; end
         8'h4E: begin kb = 15'd6144;  ways_o = 5'd24; end
         8'h60: begin kb = 15'd16;    ways_o = 5'd8;  end
         8'h66: begin kb = 15'd8;     ways_o = 5'd4;  end
         8'h67: begin kb = 15'd16;    ways_o = 5'd4;  end
         8'h68: begin kb = 15'd32;    ways_o = 5'd4;  end
         8'h78: begin kb = 15'd1024;  ways_o = 5'd4;  end
         8'h79: begin kb = 15'd128;   ways_o = 5'd8;  end
         8'h7A: begin kb = 15'd256;   ways_o = 5'd8;  end
         8'h7B: begin kb = 15'd512;   ways_o = 5'd8;  end
         8'h7C: begin kb = 15'd1024;  ways_o = 5'd8;  end
         8'h7D: begin kb = 15'd2048;  ways_o = 5'd8;  end
         8'h7F: begin kb = 15'd512;   ways_o = 5'd2;  end
         8'h80: begin kb = 15'd512;   ways_o = 5'd8;  end
         8'h82: begin kb = 15'd256;   ways_o = 5'd8;  end
         8'h83: begin kb = 15'd512;   ways_o = 5'd8;  end
         8'h84: begin kb = 15'd1024;  ways_o = 5'd8;  end
         8'h85: begin kb = 15'd2048;  ways_o = 5'd8;  end
         8'h86: begin kb = 15'd512;   ways_o = 5'd4;  end
         8'h87: begin kb = 15'd1024;  ways_o = 5'd8;  end
         8'hD0: begin kb = 15'd512;   ways_o = 5'd4;  end
         8'hD1: begin kb = 15'd1024;  ways_o = 5'd4;  end
         8'hD2: begin kb = 15'd2048;  ways_o = 5'd4;  end
         8'hD6: begin kb = 15'd1024;  ways_o = 5'd8;  end
         8'hD7: begin kb = 15'd2048;  ways_o = 5'd8;  end
         8'hD8: begin kb = 15'd4096;  ways_o = 5'd8;  end
         8'hDC: begin kb = 15'd1536;  ways_o = 5'd12; end
         8'hDD: begin kb = 15'd3072;  ways_o = 5'd12; end
         8'hDE: begin kb = 15'd6144;  ways_o = 5'd12; end
         8'hE2: begin kb = 15'd2048;  ways_o = 5'd16; end
         8'hE3: begin kb = 15'd4096;  ways_o = 5'd16; end
         8'hE4: begin kb = 15'd8192;  ways_o = 5'd16; end
         8'hEA: begin kb = 15'd12288; ways_o = 5'd24; end
         8'hEB: begin kb = 15'd18432; ways_o = 5'd24; end
         8'hEC: begin kb = 15'd24576; ways_o = 5'd24; end
         default: begin kb = '0; ways_o = '0; end
      endcase
   end

   // KiB to bytes
   assign size_o = {{(lct_pkg::SIZE_W-lct_pkg::KB_W-10){1'b0}}, kb, 10'b0};

endmodule

@@ rtl/lct_sat_mul.sv @@
// Shared saturating multiplier: 32-bit operand times a factor of up to 4096,
// clamped to all ones when the product leaves 32 bits.
module lct_sat_mul (
   input  logic [lct_pkg::SIZE_W-1:0]   a_i,
   input  logic [lct_pkg::FACTOR_W-1:0] b_i,
   output logic [lct_pkg::SIZE_W-1:0]   p_o
);

   localparam int unsigned PROD_W = lct_pkg::SIZE_W + lct_pkg::FACTOR_W;

   logic [PROD_W-1:0] prod;

   assign prod = {{lct_pkg::FACTOR_W{1'b0}}, a_i} * {{lct_pkg::SIZE_W{1'b0}}, b_i};
   assign p_o  = (|prod[PROD_W-1:lct_pkg::SIZE_W]) ? '1 : prod[lct_pkg::SIZE_W-1:0];

endmodule
